FILE: sv/nfsa_pkg.sv
// nfsa_pkg: shared types and constants of the next-fit slot allocator
// no dependencies; used by the channel interface, the core and the testbench

package nfsa_pkg;

    localparam int CMD_W    = 1;
    localparam int SLOT_W   = 4;
    localparam int ACTIVE_W = 5;
    localparam int FREE_W   = 5;

    // the used bitmap is kept in memory rows of this many slots
    localparam int ROW_BITS  = 8;
    localparam int ROW_BIT_W = 3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    typedef logic [ACTIVE_W-1:0] active_t;
    typedef logic [ROW_BITS-1:0] row_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] granted_slot;
        logic [FREE_W-1:0] free_count;
    } rsp_t;

endpackage

FILE: sv/nfsa_chan_if.sv
// nfsa_chan_if: valid/ready channel carrying one payload per transfer
// payload type defaults to the package request type; depends on nfsa_pkg

interface nfsa_chan_if #(
    parameter type data_t = nfsa_pkg::req_t
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/nfsa_ram.sv
// nfsa_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module nfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: sv/next_fit_slot_allocator_core.sv
// Next-fit slot allocator. The used mark of every slot lives in a small memory of 8-slot rows
// with a registered read; a request reads a row, searches it and writes it back, one
// request at a time. An allocate searches the cursor's row first and then visits further
// rows one after another until it finds a free slot or has visited every row in capacity,
// the start row twice. A release reads the row, checks the slot and writes the row back;
// requests rejected on the counters or the slot range alone are answered without a memory read.
// After reset and after every write of active_slots, a clearing pass zeroes the memory row by row;
// no request is taken during it. A finished result waits in an output register, so the
// next request can be taken while the previous result is not yet transferred.
// depends on nfsa_pkg, nfsa_chan_if and nfsa_ram

module next_fit_slot_allocator_core #(
    parameter int SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    nfsa_chan_if.sink          cfg,
    nfsa_chan_if.sink          req,
    nfsa_chan_if.source        rsp
);
    localparam int ROW_BITS = nfsa_pkg::ROW_BITS;
    localparam int BW       = nfsa_pkg::ROW_BIT_W;
    localparam int ROWS     = (SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int GW       = RAW + BW;
    localparam int CW       = $clog2(SLOTS + 1);
    localparam int VW       = $clog2(ROWS + 1);
    localparam int MW0      = (GW > CW) ? GW : CW;
    localparam int XW       = ((MW0 > nfsa_pkg::ACTIVE_W) ? MW0 : nfsa_pkg::ACTIVE_W) + 1;
    localparam int CAP_RST  = (int'(nfsa_pkg::ACTIVE_RST) > SLOTS) ? SLOTS
                                                                  : int'(nfsa_pkg::ACTIVE_RST);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_CHECK = 5'b01000,
        S_HOLD  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [RAW-1:0]       clr_row_reg, clr_row_next;
    logic [CW-1:0]        cap_reg, cap_next;
    logic [CW-1:0]        free_reg, free_next;
    logic [GW-1:0]        pos_reg, pos_next;
    logic [RAW-1:0]       row_reg, row_next;
    logic [BW-1:0]        start_bit_reg, start_bit_next;
    logic                 first_reg, first_next;
    logic [VW-1:0]        vis_reg, vis_next;
    logic [GW-1:0]        rel_slot_reg, rel_slot_next;
    nfsa_pkg::rsp_t       res_reg, res_next;
    nfsa_pkg::rsp_t       out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 ram_we;
    logic [RAW-1:0]       ram_waddr;
    nfsa_pkg::row_t       ram_wdata;
    logic [RAW-1:0]       ram_raddr;
    nfsa_pkg::row_t       ram_rdata;

    logic [XW-1:0]        cfg_x;
    logic [XW-1:0]        cap_x;
    logic [XW-1:0]        cap_m1_x;
    logic [RAW-1:0]       last_row;
    logic [GW-1:0]        eff_pos;
    logic [GW-1:0]        req_slot;
    logic [ROW_BITS-1:0]  cand;
    logic                 hit;
    logic [BW-1:0]        hit_bit;
    logic                 out_free;
    logic                 fin;
    nfsa_pkg::rsp_t       fin_rsp;
    logic                 req_fire;

    nfsa_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_used_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg.ready = (state_reg == S_IDLE);
    assign req.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
    assign out_free  = !out_valid_reg || rsp.ready;

    // capacity derived from a register write, saturated to 1..SLOTS
    always_comb
    begin
        cfg_x = XW'(cfg.data);
        if (cfg_x == XW'(0))
        begin
            cap_x = XW'(1);
        end
        else if (cfg_x > XW'(SLOTS))
        begin
            cap_x = XW'(SLOTS);
        end
        else
        begin
            cap_x = cfg_x;
        end
    end

    assign cap_m1_x = XW'(cap_reg) - XW'(1);
    assign last_row = cap_m1_x[GW-1:BW];
    assign eff_pos  = (XW'(pos_reg) >= XW'(cap_reg)) ? GW'(0) : pos_reg;
    assign req_slot = GW'(req.data.slot);

    // free bits of the row just read, inside capacity and not before the cursor on first visit
    always_comb
    begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int b = 0; b < ROW_BITS; b++)
        begin
            cand[b] = !ram_rdata[b]
                && (XW'({row_reg, BW'(b)}) < XW'(cap_reg))
                && (!first_reg || (BW'(b) >= start_bit_reg));
        end
        for (int b = ROW_BITS - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                hit     = 1'b1;
                hit_bit = BW'(b);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        cap_next       = cap_reg;
        free_next      = free_reg;
        pos_next       = pos_reg;
        row_next       = row_reg;
        start_bit_next = start_bit_reg;
        first_next     = first_reg;
        vis_next       = vis_reg;
        rel_slot_next  = rel_slot_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = clr_row_reg;
        ram_wdata      = '0;
        ram_raddr      = eff_pos[GW-1:BW];
        fin            = 1'b0;
        fin_rsp.status       = nfsa_pkg::ST_OK;
        fin_rsp.granted_slot = '0;
        fin_rsp.free_count   = nfsa_pkg::FREE_W'(free_reg);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_row_reg;
                ram_wdata = '0;
                if (clr_row_reg == RAW'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_row_next = clr_row_reg + RAW'(1);
                end
            end
            S_IDLE:
            begin
                if (cfg.valid)
                begin
                    cap_next     = CW'(cap_x);
                    free_next    = CW'(cap_x);
                    pos_next     = '0;
                    clr_row_next = '0;
                    state_next   = S_CLEAR;
                end
                else if (req_fire)
                begin
                    if (req.data.cmd == nfsa_pkg::CMD_ALLOC)
                    begin
                        if (free_reg == CW'(0))
                        begin
                            fin            = 1'b1;
                            fin_rsp.status = nfsa_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_raddr      = eff_pos[GW-1:BW];
                            row_next       = eff_pos[GW-1:BW];
                            start_bit_next = eff_pos[BW-1:0];
                            first_next     = 1'b1;
                            vis_next       = '0;
                            state_next     = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (free_reg >= cap_reg)
                        begin
                            fin            = 1'b1;
                            fin_rsp.status = nfsa_pkg::ST_EMPTY;
                        end
                        else if (XW'(req_slot) >= XW'(cap_reg))
                        begin
                            fin            = 1'b1;
                            fin_rsp.status = nfsa_pkg::ST_BAD;
                        end
                        else
                        begin
                            ram_raddr     = req_slot[GW-1:BW];
                            rel_slot_next = req_slot;
                            state_next    = S_CHECK;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = row_reg;
                    ram_wdata = ram_rdata | (nfsa_pkg::row_t'(1) << hit_bit);
                    pos_next  = {row_reg, hit_bit};
                    free_next = free_reg - CW'(1);
                    fin       = 1'b1;
                    fin_rsp.status       = nfsa_pkg::ST_OK;
                    fin_rsp.granted_slot = nfsa_pkg::SLOT_W'({row_reg, hit_bit});
                    fin_rsp.free_count   = nfsa_pkg::FREE_W'(free_reg - CW'(1));
                end
                else if (XW'(vis_reg) == XW'(last_row) + XW'(1))
                begin
                    // every row visited, start row twice: no free slot after all
                    fin            = 1'b1;
                    fin_rsp.status = nfsa_pkg::ST_FULL;
                end
                else
                begin
                    row_next   = (row_reg == last_row) ? RAW'(0) : row_reg + RAW'(1);
                    ram_raddr  = row_next;
                    first_next = 1'b0;
                    vis_next   = vis_reg + VW'(1);
                end
            end
            S_CHECK:
            begin
                if (!ram_rdata[rel_slot_reg[BW-1:0]])
                begin
                    fin            = 1'b1;
                    fin_rsp.status = nfsa_pkg::ST_BAD;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rel_slot_reg[GW-1:BW];
                    ram_wdata = ram_rdata
                        & ~(nfsa_pkg::row_t'(1) << rel_slot_reg[BW-1:0]);
                    pos_next  = rel_slot_reg;
                    free_next = free_reg + CW'(1);
                    fin       = 1'b1;
                    fin_rsp.status     = nfsa_pkg::ST_OK;
                    fin_rsp.free_count = nfsa_pkg::FREE_W'(free_reg + CW'(1));
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // result goes straight to the output register when it is free, else waits
        if (fin)
        begin
            if (out_free)
            begin
                out_next       = fin_rsp;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = fin_rsp;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_row_reg   <= '0;
            cap_reg       <= CW'(CAP_RST);
            free_reg      <= CW'(CAP_RST);
            pos_reg       <= '0;
            first_reg     <= 1'b0;
            vis_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            cap_reg       <= cap_next;
            free_reg      <= free_next;
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            vis_reg       <= vis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        start_bit_reg <= start_bit_next;
        rel_slot_reg  <= rel_slot_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

`ifndef SYNTHESIS
    a_free_within_cap: assert property (
        @(posedge clk) disable iff (!rst_n)
        free_reg <= cap_reg
    ) else $error("free count exceeds capacity");

    a_no_write_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_HOLD) |-> !ram_we
    ) else $error("used memory written outside a request");

    a_result_has_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fin || state_reg == S_HOLD)
    ) else $error("result appeared without a finished request");

    a_hold_keeps_input_closed: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> !req.ready && !cfg.ready
    ) else $error("request taken while a result is parked");
`endif
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for next_fit_slot_allocator_core with a built-in pool model
// depends on nfsa_pkg, nfsa_chan_if and the core with its row memory

module testbench;

    // model of the pool as seen from outside
    typedef struct packed {
        logic [15:0]                   used;
        logic [nfsa_pkg::SLOT_W-1:0]   cursor;
        logic [nfsa_pkg::FREE_W-1:0]   free;
        logic [nfsa_pkg::ACTIVE_W-1:0] active;
    } pool_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    nfsa_chan_if #(.data_t(nfsa_pkg::active_t)) cfg_ch ();
    nfsa_chan_if #(.data_t(nfsa_pkg::req_t))    req_ch ();
    nfsa_chan_if #(.data_t(nfsa_pkg::rsp_t))    rsp_ch ();

    next_fit_slot_allocator_core #(.SLOTS(16)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    nfsa_pkg::req_t  req_backlog[$];
    nfsa_pkg::rsp_t  rsp_due[$];
    pool_t           plan_pool;
    pool_t           live_pool;
    nfsa_pkg::rsp_t  want;
    bit    idle_on = 1'b1;
    int    req_gap = 0;
    int    rsp_gap = 0;
    int    errors = 0;
    int    n_grant = 0;
    int    n_free = 0;
    int    n_full = 0;
    int    n_empty = 0;
    int    n_bad = 0;
    int    n_setups = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [nfsa_pkg::FREE_W-1:0] capacity_of(input nfsa_pkg::active_t v);
        if (v == '0)
            return 5'd1;
        if (v > 5'd16)
            return 5'd16;
        return v;
    endfunction

    function automatic pool_t fresh_pool(input nfsa_pkg::active_t v);
        pool_t p;
        p.used   = '0;
        p.cursor = '0;
        p.free   = capacity_of(v);
        p.active = v;
        return p;
    endfunction

    // serves one request against the pool and returns its response
    function automatic nfsa_pkg::rsp_t allot(inout pool_t p, input nfsa_pkg::req_t r);
        nfsa_pkg::rsp_t              res;
        logic [nfsa_pkg::FREE_W-1:0] cap;
        logic [nfsa_pkg::SLOT_W-1:0] pos;
        logic                        hit;
        cap = capacity_of(p.active);
        res.status = nfsa_pkg::ST_OK;
        res.granted_slot = '0;
        if ({1'b0, p.cursor} >= cap)
            p.cursor = '0;
        if (r.cmd == nfsa_pkg::CMD_ALLOC)
        begin
            if (p.free == '0)
                res.status = nfsa_pkg::ST_FULL;
            else
            begin
                pos = p.cursor;
                hit = 1'b0;
                for (int n = 0; n < cap; n++)
                begin
                    if (!hit && !p.used[pos])
                        hit = 1'b1;
                    else if (!hit)
                        pos = ({1'b0, pos} + 5'd1 == cap) ? 4'd0 : pos + 4'd1;
                end
                if (hit)
                begin
                    p.used[pos] = 1'b1;
                    p.cursor = pos;
                    p.free = p.free - 5'd1;
                    res.granted_slot = pos;
                end
                else
                    res.status = nfsa_pkg::ST_FULL;
            end
        end
        else
        begin
            if (p.free >= cap)
                res.status = nfsa_pkg::ST_EMPTY;
            else if ({1'b0, r.slot} >= cap || !p.used[r.slot])
                res.status = nfsa_pkg::ST_BAD;
            else
            begin
                p.used[r.slot] = 1'b0;
                p.cursor = r.slot;
                p.free = p.free + 5'd1;
            end
        end
        res.free_count = p.free;
        return res;
    endfunction

    task automatic add_item(input logic [nfsa_pkg::CMD_W-1:0] c,
                            input logic [nfsa_pkg::SLOT_W-1:0] s);
        nfsa_pkg::req_t r;
        r.cmd = c;
        r.slot = s;
        void'(allot(plan_pool, r));
        req_backlog.push_back(r);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_ch.valid || rsp_due.size() != 0);
    endtask

    task automatic write_active(input nfsa_pkg::active_t v);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        plan_pool = fresh_pool(v);
        n_setups++;
    endtask

    // mostly fill/drain runs with releases of slots that are really held, some noise
    task automatic add_random(input int count);
        logic [nfsa_pkg::SLOT_W-1:0] held[$];
        logic [nfsa_pkg::FREE_W-1:0] cap;
        bit                          filling;
        int                          r;
        filling = 1'b1;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                filling = !filling;
            cap = capacity_of(plan_pool.active);
            r = $urandom_range(0, 99);
            if (r < 10)
                add_item(nfsa_pkg::CMD_W'($urandom_range(0, 1)),
                         nfsa_pkg::SLOT_W'($urandom_range(0, 15)));
            else if (filling ? (r < 75) : (r < 35))
                add_item(nfsa_pkg::CMD_ALLOC, nfsa_pkg::SLOT_W'($urandom_range(0, 15)));
            else
            begin
                held.delete();
                for (int i = 0; i < 16; i++)
                    if (i < cap && plan_pool.used[i])
                        held.push_back(nfsa_pkg::SLOT_W'(i));
                if (held.size() != 0)
                    add_item(nfsa_pkg::CMD_RELEASE, held[$urandom_range(0, held.size() - 1)]);
                else
                    add_item(nfsa_pkg::CMD_RELEASE, nfsa_pkg::SLOT_W'($urandom_range(0, 15)));
            end
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!req_ch.valid || req_ch.ready)
        begin
            if (req_gap > 0)
            begin
                req_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (req_backlog.size() != 0)
            begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= req_backlog.pop_front();
                if (idle_on && $urandom_range(0, 3) == 0)
                    req_gap = $urandom_range(1, 14);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // response sink with stall bursts
    always @(posedge clk)
    begin
        if (rsp_gap > 0)
        begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 15) == 0)
        begin
            rsp_gap = $urandom_range(0, 13);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // monitor: predicts on each request transfer, checks each response transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                live_pool = fresh_pool(cfg_ch.data);
            if (req_ch.valid && req_ch.ready)
                rsp_due.push_back(allot(live_pool, req_ch.data));
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response with none outstanding: status %0d slot %0d free %0d",
                           rsp_ch.data.status, rsp_ch.data.granted_slot,
                           rsp_ch.data.free_count);
                    errors++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp_ch.data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status,
                               rsp_ch.data.status);
                        errors++;
                    end
                    if (rsp_ch.data.granted_slot !== want.granted_slot)
                    begin
                        $error("granted_slot: expected %0d, got %0d", want.granted_slot,
                               rsp_ch.data.granted_slot);
                        errors++;
                    end
                    if (rsp_ch.data.free_count !== want.free_count)
                    begin
                        $error("free_count: expected %0d, got %0d", want.free_count,
                               rsp_ch.data.free_count);
                        errors++;
                    end
                    if (want.status == nfsa_pkg::ST_FULL)
                        n_full++;
                    else if (want.status == nfsa_pkg::ST_EMPTY)
                        n_empty++;
                    else if (want.status == nfsa_pkg::ST_BAD)
                        n_bad++;
                end
            end
        end
    end

    // tally requests by kind at transfer
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            if (req_ch.data.cmd == nfsa_pkg::CMD_ALLOC)
                n_grant++;
            else
                n_free++;
        end
    end

    initial
    begin
        nfsa_pkg::active_t plan[8];
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        plan_pool = fresh_pool(nfsa_pkg::ACTIVE_RST);
        live_pool = fresh_pool(nfsa_pkg::ACTIVE_RST);
        plan = '{5'd1, 5'd0, 5'd31, 5'd7, 5'd17, 5'd2, 5'd12, 5'd16};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full 16-slot pool: release while empty, fill, overflow, bad and good releases
        add_item(nfsa_pkg::CMD_RELEASE, 4'd0);
        for (int i = 0; i < 16; i++)
            add_item(nfsa_pkg::CMD_ALLOC, 4'hf);
        add_item(nfsa_pkg::CMD_ALLOC, 4'd0);
        add_item(nfsa_pkg::CMD_RELEASE, 4'd15);
        add_item(nfsa_pkg::CMD_RELEASE, 4'd15);
        add_item(nfsa_pkg::CMD_RELEASE, 4'd5);
        add_item(nfsa_pkg::CMD_ALLOC, 4'd0);
        wait_drained();

        // small pool: release beyond capacity and of a slot never taken
        write_active(5'd4);
        add_item(nfsa_pkg::CMD_ALLOC, 4'd0);
        add_item(nfsa_pkg::CMD_RELEASE, 4'd9);
        add_item(nfsa_pkg::CMD_RELEASE, 4'd3);
        add_item(nfsa_pkg::CMD_RELEASE, 4'd0);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_active(plan[ph]);
            if (ph == 7)
                idle_on = 1'b0;
            add_random(50);
            if (ph == 0)
                wait_drained();
            add_random(50);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("ran %0d allocate and %0d release requests over %0d pool setups",
                 n_grant, n_free, n_setups);
        $display("rejections seen: %0d pool full, %0d pool empty, %0d bad release",
                 n_full, n_empty, n_bad);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: next_fit_slot_allocator_core.f
sv/nfsa_pkg.sv
sv/nfsa_chan_if.sv
sv/nfsa_ram.sv
sv/next_fit_slot_allocator_core.sv
tb/testbench.sv
